// ----- rtl/bscc_pkg.sv -----
`default_nettype none

package bscc_pkg;

    localparam int MAP_BYTES = 128;
    localparam int MAP_BITS  = MAP_BYTES * 8;
    localparam int ADDR_W    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int CNT_W     = $clog2(MAP_BITS + 1);
    localparam int IDX_W     = 16;
    localparam int BYTE_NO_W = IDX_W - 3;
    localparam int ONES_W    = 11;
    localparam int POS_W     = 10;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [ONES_W-1:0]    ones_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [BYTE_NO_W-1:0] byte_no_t;

    typedef enum logic [3:0] {
        FN_SET_ALL   = 4'd0,
        FN_CLEAR_ALL = 4'd1,
        FN_SET       = 4'd2,
        FN_CLEAR     = 4'd3,
        FN_TOGGLE    = 4'd4,
        FN_TEST      = 4'd5,
        FN_COUNT     = 4'd6,
        FN_FIRST     = 4'd7,
        FN_LAST      = 4'd8
    } func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MODIFY,
        S_SCAN,
        S_DONE
    } state_t;

    function automatic logic [3:0] byte_ones(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < 8; k++) begin
            c = c + {3'd0, b[k]};
        end
        return c;
    endfunction

    // lowest set bit of a byte, zero when the byte is empty
    function automatic logic [2:0] low_one(input logic [7:0] b);
        logic [2:0] p;
        p = '0;
        for (int k = 7; k >= 0; k--) begin
            if (b[k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

    function automatic logic [2:0] high_one(input logic [7:0] b);
        logic [2:0] p;
        p = '0;
        for (int k = 0; k < 8; k++) begin
            if (b[k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bitmap_set_clear_count_find_core.sv -----
// Bit map of 1024 bits held in a 128 x 8 synchronous RAM with one read and
// one write port. Each request word yields exactly one result word. Set,
// clear, toggle and test go through a read-modify-write of one byte: it is
// read when the request is taken and written back in the modify state, and
// the result word is loaded into the output register in the done state.
// Count, find lowest and find highest sweep the whole RAM one byte per cycle
// through its single read port. Set all and clear all go straight to the
// done state: per-byte valid flags are dropped and a fill value is
// recorded, and a byte not written since reads as that fill value.
// A new request is taken only once the previous one has reached the output
// register; the output register holds a result while the sink stalls, and
// any such stall keeps the core waiting in the done state.
// Out-of-range set, clear, toggle and test leave the map untouched and raise
// out_of_range; like the unused function codes, they go straight to done.
`default_nettype none

module bitmap_set_clear_count_find_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  func,
    input  wire logic [15:0] bit_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             bit_value,
    output logic [10:0]      ones_count,
    output logic             found,
    output logic [9:0]       position,
    output logic             out_of_range
);

    bscc_pkg::state_t state_reg, state_next;

    logic [7:0]           store_mem [bscc_pkg::MAP_BYTES];
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;
    logic [bscc_pkg::MAP_BYTES-1:0] valid_reg;
    logic                 fill_reg;

    logic [3:0]           func_reg;
    logic [2:0]           bit_sel_reg;
    bscc_pkg::addr_t      byte_addr_reg;
    bscc_pkg::addr_t      rx_idx_reg;
    logic                 bit_value_reg;
    bscc_pkg::cnt_t       count_reg;
    logic                 found_reg;
    bscc_pkg::pos_t       pos_reg;
    logic                 oor_reg;

    logic                 out_valid_reg;
    logic                 out_bit_reg;
    bscc_pkg::ones_t      out_ones_reg;
    logic                 out_found_reg;
    bscc_pkg::pos_t       out_pos_reg;
    logic                 out_oor_reg;

    logic                 accept;
    logic                 in_single;
    logic                 in_scan;
    logic                 in_range;
    bscc_pkg::byte_no_t   in_byte_no;
    logic                 scan_last;
    logic                 out_free;
    logic                 out_load;
    logic [7:0]           cur_byte;
    logic [7:0]           bit_mask;
    bscc_pkg::addr_t      mem_rd_addr;
    logic                 mem_we;
    logic [7:0]           mem_wdata;

    assign in_byte_no = bit_index[15:3];
    assign in_range   = {{(32 - bscc_pkg::BYTE_NO_W){1'b0}}, in_byte_no}
                        < 32'(bscc_pkg::MAP_BYTES);
    assign in_single  = (func == bscc_pkg::FN_SET) || (func == bscc_pkg::FN_CLEAR)
                        || (func == bscc_pkg::FN_TOGGLE) || (func == bscc_pkg::FN_TEST);
    assign in_scan    = (func == bscc_pkg::FN_COUNT) || (func == bscc_pkg::FN_FIRST)
                        || (func == bscc_pkg::FN_LAST);
    assign accept     = in_valid && !in_stall;
    assign scan_last  = (rx_idx_reg == bscc_pkg::addr_t'(bscc_pkg::MAP_BYTES - 1));
    assign out_free   = !out_valid_reg || !out_stall;

    // bytes not written since the last set all / clear all read as the fill value
    assign cur_byte = rd_valid_reg ? rd_data_reg : {8{fill_reg}};
    assign bit_mask = 8'd1 << bit_sel_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bscc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_single && in_range)
                    begin
                        state_next = bscc_pkg::S_MODIFY;
                    end
                    else if (in_scan)
                    begin
                        state_next = bscc_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = bscc_pkg::S_DONE;
                    end
                end
            end
            bscc_pkg::S_MODIFY:
            begin
                state_next = bscc_pkg::S_DONE;
            end
            bscc_pkg::S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = bscc_pkg::S_DONE;
                end
            end
            bscc_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = bscc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bscc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall    = 1'b1;
        mem_rd_addr = '0;
        mem_we      = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            bscc_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (!in_scan)
                begin
                    mem_rd_addr = bscc_pkg::addr_t'(in_byte_no);
                end
            end
            bscc_pkg::S_MODIFY:
            begin
                mem_we = 1'b1;
            end
            bscc_pkg::S_SCAN:
            begin
                mem_rd_addr = rx_idx_reg + bscc_pkg::addr_t'(1);
            end
            bscc_pkg::S_DONE:
            begin
                out_load = out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        case (func_reg)
            bscc_pkg::FN_SET:    mem_wdata = cur_byte | bit_mask;
            bscc_pkg::FN_CLEAR:  mem_wdata = cur_byte & ~bit_mask;
            bscc_pkg::FN_TOGGLE: mem_wdata = cur_byte ^ bit_mask;
            default:             mem_wdata = cur_byte;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[byte_addr_reg] <= mem_wdata;
        end
        rd_data_reg  <= store_mem[mem_rd_addr];
        rd_valid_reg <= valid_reg[mem_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bscc_pkg::S_IDLE;
            valid_reg     <= '0;
            fill_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (func == bscc_pkg::FN_SET_ALL))
            begin
                valid_reg <= '0;
                fill_reg  <= 1'b1;
            end
            else if (accept && (func == bscc_pkg::FN_CLEAR_ALL))
            begin
                valid_reg <= '0;
                fill_reg  <= 1'b0;
            end
            else if (mem_we)
            begin
                valid_reg[byte_addr_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func;
            bit_sel_reg   <= bit_index[2:0];
            byte_addr_reg <= bscc_pkg::addr_t'(in_byte_no);
            rx_idx_reg    <= '0;
            bit_value_reg <= 1'b0;
            count_reg     <= '0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            oor_reg       <= in_single && !in_range;
        end
        else if (state_reg == bscc_pkg::S_MODIFY)
        begin
            bit_value_reg <= (func_reg == bscc_pkg::FN_TEST) && ((cur_byte & bit_mask) != 8'd0);
        end
        else if (state_reg == bscc_pkg::S_SCAN)
        begin
            rx_idx_reg <= rx_idx_reg + bscc_pkg::addr_t'(1);
            if (func_reg == bscc_pkg::FN_COUNT)
            begin
                count_reg <= count_reg + bscc_pkg::cnt_t'(bscc_pkg::byte_ones(cur_byte));
            end
            // lowest: keep the first hit; highest: let every later hit overwrite
            if ((cur_byte != 8'd0) && (((func_reg == bscc_pkg::FN_FIRST) && !found_reg)
                                       || (func_reg == bscc_pkg::FN_LAST)))
            begin
                found_reg <= 1'b1;
                if (func_reg == bscc_pkg::FN_FIRST)
                begin
                    pos_reg <= bscc_pkg::pos_t'({rx_idx_reg, bscc_pkg::low_one(cur_byte)});
                end
                else
                begin
                    pos_reg <= bscc_pkg::pos_t'({rx_idx_reg, bscc_pkg::high_one(cur_byte)});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_bit_reg   <= bit_value_reg;
            out_ones_reg  <= bscc_pkg::ones_t'(count_reg);
            out_found_reg <= found_reg;
            out_pos_reg   <= pos_reg;
            out_oor_reg   <= oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bit_value    = out_bit_reg;
    assign ones_count   = out_ones_reg;
    assign found        = out_found_reg;
    assign position     = out_pos_reg;
    assign out_of_range = out_oor_reg;

endmodule

`default_nettype wire

// ----- rtl/bscc_checker.sv -----
`default_nettype none

module bscc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        bit_value,
    input wire logic [10:0] ones_count,
    input wire logic        found,
    input wire logic [9:0]  position,
    input wire logic        out_of_range
);

    // a held word must not vanish while the sink stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_oor_bit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> !bit_value && !found && (ones_count == 11'd0))
        else $error("out-of-range word carries other results");

    a_pos_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> (position == 10'd0))
        else $error("position reported without a set bit");

    a_count_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ones_count != 11'd0) |-> !found && !bit_value)
        else $error("count word mixes in other results");

    // one request in flight: no word taken in the cycle after one is taken
    a_one_at_once: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken straight after the first");

endmodule

bind bitmap_set_clear_count_find_core bscc_checker u_bscc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .bit_value    (bit_value),
    .ones_count   (ones_count),
    .found        (found),
    .position     (position),
    .out_of_range (out_of_range)
);

`default_nettype wire

// ----- dv/bitmap_set_clear_count_find_core_tb.sv -----
`default_nettype none

module bitmap_set_clear_count_find_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bscc_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = MAP_BYTES + 16;
    localparam int FN_FIRST_UNUSED = int'(FN_LAST) + 1;

    typedef struct packed {
        logic  bit_value;
        ones_t ones_count;
        logic  found;
        pos_t  position;
        logic  out_of_range;
    } map_result_t;

    typedef struct {
        logic [3:0]  fn;
        logic [15:0] idx;
        map_result_t res;
    } pending_word_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [3:0]  func      = '0;
    logic [15:0] bit_index = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic        bit_value;
    ones_t       ones_count;
    logic        found;
    pos_t        position;
    logic        out_of_range;

    logic [7:0]    shadow_map [MAP_BYTES];
    pending_word_t pending_results [$];
    int            mismatches  = 0;
    int            cycle_count = 0;
    int            burst_left  = 0;
    int            stall_mode  = 0;

    bitmap_set_clear_count_find_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .bit_index    (bit_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .bit_value    (bit_value),
        .ones_count   (ones_count),
        .found        (found),
        .position     (position),
        .out_of_range (out_of_range)
    );

    always #1 clk = ~clk;

    // Apply one request to the shadow map and return the result it yields.
    function automatic map_result_t apply_request(input logic [3:0] fn, input logic [15:0] idx);
        map_result_t r;
        int          byte_no;
        logic [7:0]  mask;
        int          total;
        r       = '0;
        byte_no = int'(idx >> 3);
        mask    = 8'h01 << idx[2:0];
        total   = 0;
        case (fn)
            FN_SET_ALL:
            begin
                foreach (shadow_map[i])
                begin
                    shadow_map[i] = 8'hFF;
                end
            end
            FN_CLEAR_ALL:
            begin
                foreach (shadow_map[i])
                begin
                    shadow_map[i] = 8'h00;
                end
            end
            FN_SET, FN_CLEAR, FN_TOGGLE, FN_TEST:
            begin
                if (byte_no >= MAP_BYTES)
                begin
                    r.out_of_range = 1'b1;
                end
                else if (fn == FN_SET)
                begin
                    shadow_map[byte_no] = shadow_map[byte_no] | mask;
                end
                else if (fn == FN_CLEAR)
                begin
                    shadow_map[byte_no] = shadow_map[byte_no] & ~mask;
                end
                else if (fn == FN_TOGGLE)
                begin
                    shadow_map[byte_no] = shadow_map[byte_no] ^ mask;
                end
                else
                begin
                    r.bit_value = |(shadow_map[byte_no] & mask);
                end
            end
            FN_COUNT:
            begin
                for (int i = 0; i < MAP_BYTES; i++)
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        total += int'(shadow_map[i][k]);
                    end
                end
                r.ones_count = ones_t'(total);
            end
            FN_FIRST:
            begin
                for (int n = 0; n < MAP_BITS; n++)
                begin
                    if (!r.found && shadow_map[n / 8][n % 8])
                    begin
                        r.found    = 1'b1;
                        r.position = pos_t'(n);
                    end
                end
            end
            FN_LAST:
            begin
                for (int n = MAP_BITS - 1; n >= 0; n--)
                begin
                    if (!r.found && shadow_map[n / 8][n % 8])
                    begin
                        r.found    = 1'b1;
                        r.position = pos_t'(n);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        mismatches++;
    endtask

    task automatic send_word(input logic [3:0] fn, input logic [15:0] idx);
        pending_word_t w;
        int            gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        func      <= fn;
        bit_index <= idx;
        do @(posedge clk); while (in_stall);
        w.fn  = fn;
        w.idx = idx;
        w.res = apply_request(fn, idx);
        pending_results.push_back(w);
    endtask

    // Hold the sender off until every outstanding word has come back.
    task automatic wait_for_results();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_reset_state();
        send_word(FN_COUNT, 16'd0);
        send_word(FN_FIRST, 16'd0);
        send_word(FN_LAST, 16'd0);
        send_word(FN_TEST, 16'd0);
    endtask

    task automatic test_single_bits();
        send_word(FN_SET, 16'd0);
        send_word(FN_SET, 16'(MAP_BITS - 1));
        send_word(FN_FIRST, 16'd0);
        send_word(FN_LAST, 16'd0);
        send_word(FN_COUNT, 16'd0);
        send_word(FN_TOGGLE, 16'(MAP_BITS - 1));
        send_word(FN_TEST, 16'(MAP_BITS - 1));
        send_word(FN_CLEAR, 16'd0);
        send_word(FN_COUNT, 16'd0);
    endtask

    task automatic test_out_of_range();
        send_word(FN_SET, 16'(MAP_BITS));
        send_word(FN_TOGGLE, 16'hFFFF);
        send_word(FN_CLEAR, 16'hFFFF);
        send_word(FN_TEST, 16'(MAP_BITS));
        send_word(FN_COUNT, 16'd0);
    endtask

    task automatic test_fill_and_empty();
        send_word(FN_SET_ALL, 16'd0);
        send_word(FN_COUNT, 16'd0);
        send_word(FN_CLEAR, 16'(MAP_BITS / 2));
        send_word(FN_TEST, 16'(MAP_BITS / 2));
        send_word(FN_COUNT, 16'd0);
        send_word(FN_CLEAR_ALL, 16'd0);
        send_word(FN_LAST, 16'd0);
    endtask

    task automatic test_unused_codes();
        for (int c = FN_FIRST_UNUSED; c < 16; c++)
        begin
            send_word(4'(c), 16'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_random_mix(input int n_items);
        int          base;
        int          span;
        int          pick;
        logic [3:0]  fn;
        logic [15:0] idx;
        for (int i = 0; i < n_items; i++)
        begin
            // Move the working window now and then so finds land all over the map.
            if (i % 40 == 0)
            begin
                base = $urandom_range(0, MAP_BITS - 1);
                case ($urandom_range(0, 3))
                    0: span = $urandom_range(0, 7);
                    1: span = 63;
                    2: span = 255;
                    default: span = MAP_BITS - 1;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)      fn = FN_SET;
            else if (pick < 42) fn = FN_CLEAR;
            else if (pick < 54) fn = FN_TOGGLE;
            else if (pick < 68) fn = FN_TEST;
            else if (pick < 78) fn = FN_COUNT;
            else if (pick < 86) fn = FN_FIRST;
            else if (pick < 94) fn = FN_LAST;
            else if (pick < 96) fn = FN_SET_ALL;
            else if (pick < 98) fn = FN_CLEAR_ALL;
            else                fn = 4'($urandom_range(FN_FIRST_UNUSED, 15));
            pick = $urandom_range(0, 19);
            if (pick == 0)
            begin
                idx = 16'($urandom_range(0, 65535));
            end
            else if (pick == 1)
            begin
                idx = 16'($urandom_range(MAP_BITS - 2, MAP_BITS + 1));
            end
            else
            begin
                idx = 16'((base + $urandom_range(0, span)) % MAP_BITS);
            end
            send_word(fn, idx);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver back-pressure: switch between free-running, light, heavy and
    // periodic stalling every so often.
    always @(posedge clk)
    begin
        if (cycle_count % 97 == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= (cycle_count % 8 < 3);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        pending_word_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result word with nothing expected");
            end
            else
            begin
                w = pending_results.pop_front();
                if (bit_value !== w.res.bit_value)
                begin
                    report_mismatch($sformatf("func %0d index %0d: bit_value %0d, want %0d",
                        w.fn, w.idx, bit_value, w.res.bit_value));
                end
                if (ones_count !== w.res.ones_count)
                begin
                    report_mismatch($sformatf("func %0d index %0d: ones_count %0d, want %0d",
                        w.fn, w.idx, ones_count, w.res.ones_count));
                end
                if (found !== w.res.found)
                begin
                    report_mismatch($sformatf("func %0d index %0d: found %0d, want %0d",
                        w.fn, w.idx, found, w.res.found));
                end
                if (position !== w.res.position)
                begin
                    report_mismatch($sformatf("func %0d index %0d: position %0d, want %0d",
                        w.fn, w.idx, position, w.res.position));
                end
                if (out_of_range !== w.res.out_of_range)
                begin
                    report_mismatch($sformatf("func %0d index %0d: out_of_range %0d, want %0d",
                        w.fn, w.idx, out_of_range, w.res.out_of_range));
                end
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        foreach (shadow_map[i])
        begin
            shadow_map[i] = 8'h00;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_single_bits();
        test_out_of_range();
        test_fill_and_empty();
        test_unused_codes();
        test_random_mix(250);
        wait_for_results();
        test_random_mix(250);
        wait_for_results();
        test_random_mix(250);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
